// ===== src/ksg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksg_pkg
// Shared constants, character tables and types for the seeded key character
// generator.
// ----------------------------------------------------------------------------
package ksg_pkg;

  localparam int KEY_LENGTH_DEF = 12;

  localparam int SEED_W = 32;
  localparam int FUNC_W = 2;
  localparam int CHAR_W = 7;
  localparam int IDX_W  = 4;
  localparam int OFF_W  = 6;
  localparam int CSET_LEN = 36;

  localparam logic [SEED_W-1:0] STEP_EVEN_XOR = 32'h0004_321a;
  localparam logic [SEED_W-1:0] STEP_ODD_XOR  = 32'h9812_4557;
  localparam logic [SEED_W-1:0] STEP_ODD_SET  = 32'h8000_0000;

  // Charset family codes
  localparam logic [FUNC_W-1:0] FAM_0    = 2'd0;
  localparam logic [FUNC_W-1:0] FAM_1    = 2'd1;
  localparam logic [FUNC_W-1:0] FAM_2    = 2'd2;
  localparam logic [FUNC_W-1:0] FAM_NONE = 2'd3;

  localparam int TBL_W = CSET_LEN * 8;

  // Only the first 36 characters of each table are reachable.
  localparam logic [TBL_W-1:0] PRI_0 = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
  localparam logic [TBL_W-1:0] SEC_0 = "W0X1CDYNJU8VOZA0BKL46PQ7RS9T2E5HI3MF";
  localparam logic [TBL_W-1:0] PRI_1 = "23456789ABCDEFGHJKLMNPQRSTUVWXYZ38BZ";
  localparam logic [TBL_W-1:0] SEC_1 = "WXCDYNJU8VZABKL46PQ7RS9T2E5H3MFGPWR2";
  localparam logic [TBL_W-1:0] PRI_2 = "JKLMNPQRST23456789ABCDEFGHUVWXYZ38BK";
  localparam logic [TBL_W-1:0] SEC_2 = "E5MFJUWXCDKL46PQHAB3YNJ8VZ7RS9TR2GPW";

  // Result of one shift step
  typedef struct packed {
    logic [SEED_W-1:0] seed;
    logic [OFF_W-1:0]  off;
    logic [CHAR_W-1:0] ch;
  } step_res_t;

  // Look up one character; sec selects the secondary table of the family.
  function automatic logic [CHAR_W-1:0] cset_char(input logic [FUNC_W-1:0] fam,
                                                  input logic              sec,
                                                  input logic [OFF_W-1:0]  idx);
    logic [TBL_W-1:0] tbl;
    int               pos;
    case (fam)
      FAM_1:   tbl = sec ? SEC_1 : PRI_1;
      FAM_2:   tbl = sec ? SEC_2 : PRI_2;
      default: tbl = sec ? SEC_0 : PRI_0;
    endcase
    pos = (CSET_LEN - 1 - int'(idx)) * 8;
    return tbl[pos +: CHAR_W];
  endfunction

endpackage

// ===== src/mac_seeded_key_char_generator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mac_seeded_key_char_generator_core
// Turns a 32-bit MAC-derived seed and a charset family into a key of
// KEY_LENGTH characters, one character per output request.
// ----------------------------------------------------------------------------
// Order: a taken request is first loaded into the working registers, then
//   its first character is registered at the output; the key then streams out
//   at one character per cycle while the output is not stalled. Rate is set by
//   the single shift-step unit producing one character a cycle. The next
//   request is taken in the cycle the last character is produced.
// Requests with the unused family code are taken and dropped.
// Reset: synchronous, active high; clears the busy flag and output valid.
// ----------------------------------------------------------------------------
module mac_seeded_key_char_generator_core #(
  parameter int KEY_LENGTH = ksg_pkg::KEY_LENGTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // input requests
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ksg_pkg::SEED_W-1:0] mac_low,
  input  logic [ksg_pkg::FUNC_W-1:0] func,
  // output characters
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [ksg_pkg::CHAR_W-1:0] key_char,
  output logic [ksg_pkg::IDX_W-1:0]  char_index,
  output logic                       last_char
);

  localparam int POS_W = $clog2(KEY_LENGTH);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(KEY_LENGTH - 1);

  // working registers of the key in progress
  logic                       active;
  logic [ksg_pkg::SEED_W-1:0] seed;
  logic [ksg_pkg::FUNC_W-1:0] fam;
  logic [ksg_pkg::OFF_W-1:0]  prev;
  logic [POS_W-1:0]           pos;

  logic                       advance;
  logic                       last_step;
  logic                       in_take;
  ksg_pkg::step_res_t         res;

  ksg_step #(
    .KEY_LENGTH(KEY_LENGTH)
  ) u_step (
    .seed(seed),
    .fam (fam),
    .prev(prev),
    .pos (pos),
    .res (res)
  );

  // Advance one step whenever the output register is free or being drained.
  assign advance   = active && (!out_valid || !out_stall);
  assign last_step = (pos == LAST_POS);
  // Take a new request when idle, or as the last character goes out.
  assign in_stall  = active && !(advance && last_step);
  assign in_take   = in_valid && !in_stall;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
      pos       <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      // a new request overrides the finishing key; drop the unused family
      if (in_take) begin
        active <= (func != ksg_pkg::FAM_NONE);
        pos    <= '0;
      end else if (advance) begin
        pos <= pos + POS_W'(1);
        if (last_step) begin
          active <= 1'b0;
        end
      end
    end
  end

  // payload: seed chain and output character
  always_ff @(posedge clk) begin
    if (advance) begin
      prev       <= res.off;
      key_char   <= res.ch;
      char_index <= ksg_pkg::IDX_W'(pos);
      last_char  <= last_step;
    end
    if (in_take) begin
      seed <= mac_low;
      fam  <= func;
    end else if (advance) begin
      seed <= res.seed;
    end
  end

endmodule

// ===== src/ksg_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksg_step
// One shift step of the seed, its offset modulo 36 and the key character.
// ----------------------------------------------------------------------------
module ksg_step #(
  parameter int KEY_LENGTH = ksg_pkg::KEY_LENGTH_DEF,
  localparam int POS_W = $clog2(KEY_LENGTH)
) (
  input  logic [ksg_pkg::SEED_W-1:0] seed,
  input  logic [ksg_pkg::FUNC_W-1:0] fam,
  input  logic [ksg_pkg::OFF_W-1:0]  prev,
  input  logic [POS_W-1:0]           pos,
  output ksg_pkg::step_res_t         res
);

  logic [ksg_pkg::SEED_W-1:0] nxt;
  logic [8:0]                 fold1;
  logic [6:0]                 fold2;
  logic [3:0]                 mod9;
  logic [ksg_pkg::OFF_W-1:0]  off;
  logic [6:0]                 alt_sum;
  logic [ksg_pkg::OFF_W-1:0]  alt;

  always_comb begin
    if (seed[0] == 1'b0) begin
      nxt = (seed ^ ksg_pkg::STEP_EVEN_XOR) >> 1;
    end else begin
      nxt = ((seed ^ ksg_pkg::STEP_ODD_XOR) >> 1) | ksg_pkg::STEP_ODD_SET;
    end
  end

  // value mod 36 = ((value >> 2) mod 9) * 4 + low two bits;
  // 64 is 1 mod 9, so fold six-bit digits of the upper 30 bits.
  // Compare the folded sum against every multiple of 9 side by side and
  // take the largest one that fits.
  always_comb begin
    logic [6:0] r;
    fold1 = 9'(nxt[7:2]) + 9'(nxt[13:8]) + 9'(nxt[19:14])
          + 9'(nxt[25:20]) + 9'(nxt[31:26]);
    fold2 = 7'(fold1[8:6]) + 7'(fold1[5:0]);
    r = fold2;
    for (int k = 1; k <= 7; k++) begin
      if (fold2 >= 7'(9 * k)) begin
        r = fold2 - 7'(9 * k);
      end
    end
    mod9 = r[3:0];
  end

  assign off = {mod9, nxt[1:0]};

  // Secondary index: (previous offset + position - 1) mod 36
  always_comb begin
    alt_sum = 7'(prev) + 7'(pos) - 7'd1;
    if (alt_sum >= 7'(ksg_pkg::CSET_LEN)) begin
      alt = 6'(alt_sum - 7'(ksg_pkg::CSET_LEN));
    end else begin
      alt = alt_sum[5:0];
    end
  end

  always_comb begin
    res.seed = nxt;
    res.off  = off;
    if (pos == '0 || off != prev) begin
      res.ch = ksg_pkg::cset_char(fam, 1'b0, off);
    end else begin
      res.ch = ksg_pkg::cset_char(fam, 1'b1, alt);
    end
  end

endmodule

// ===== tb/tb_mac_seeded_key_char_generator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mac_seeded_key_char_generator_core
// Self-checking bench for the seeded key character generator. Requests are
// offered on the input channel and every key character that leaves the block
// is compared against a key predicted locally from the seed and the charset
// family. A directed table runs first, then random requests under three
// pacing regimes, including a long output hold-off and a full drain.
// ----------------------------------------------------------------------------
module tb_mac_seeded_key_char_generator_core;

  // Bench constants
  localparam int KEY_LEN     = 12;
  localparam int HOLD_CYCLES = 300;        // long output hold-off
  localparam int CYCLE_LIMIT = 400000;     // generous run limit
  localparam int DRAIN_WAIT  = KEY_LEN + 8;

  // Shift-step constants, kept independently of the design
  localparam logic [31:0] MIX_EVEN = 32'h0004_321a;
  localparam logic [31:0] MIX_ODD  = 32'h9812_4557;
  localparam logic [31:0] MIX_TOP  = 32'h8000_0000;

  // One expected key character
  typedef struct packed {
    logic [ksg_pkg::CHAR_W-1:0] ch;
    logic [ksg_pkg::IDX_W-1:0]  idx;
    logic                       last;
  } key_sym_t;

  // One row of the directed table; first_ch of zero means "predict it"
  typedef struct packed {
    logic [ksg_pkg::SEED_W-1:0] seed;
    logic [ksg_pkg::FUNC_W-1:0] fam;
    logic [7:0]                 first_ch;
  } key_req_t;

  localparam int N_ROWS = 16;

  // Character tables per family: primary and secondary. The first
  // family's secondary table is one character longer than reachable.
  string pri_set [0:2] = '{"0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ",
                           "23456789ABCDEFGHJKLMNPQRSTUVWXYZ38BZ",
                           "JKLMNPQRST23456789ABCDEFGHUVWXYZ38BK"};
  string sec_set [0:2] = '{"W0X1CDYNJU8VOZA0BKL46PQ7RS9T2E5HI3MFG",
                           "WXCDYNJU8VZABKL46PQ7RS9T2E5H3MFGPWR2",
                           "E5MFJUWXCDKL46PQHAB3YNJ8VZ7RS9TR2GPW"};

  // DUT signals; the inputs are all known from time zero
  logic                       clk        = 1'b0;
  logic                       rst        = 1'b1;
  logic                       in_valid   = 1'b0;
  logic                       in_stall;
  logic [ksg_pkg::SEED_W-1:0] mac_low    = '0;
  logic [ksg_pkg::FUNC_W-1:0] func       = ksg_pkg::FAM_0;
  logic                       out_valid;
  logic                       out_stall  = 1'b0;
  logic [ksg_pkg::CHAR_W-1:0] key_char;
  logic [ksg_pkg::IDX_W-1:0]  char_index;
  logic                       last_char;

  // Bench state
  key_sym_t pending_chars [$];   // key characters still owed by the block
  key_req_t dir_rows [0:N_ROWS-1];
  int       mismatches    = 0;
  int       cycle_cnt     = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  logic     hold_go       = 1'b0;
  logic     hold_off      = 1'b0;

  mac_seeded_key_char_generator_core #(
    .KEY_LENGTH (KEY_LEN)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mac_low    (mac_low),
    .func       (func),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .key_char   (key_char),
    .char_index (char_index),
    .last_char  (last_char)
  );

  always #5 clk = ~clk;

  // Work out the key for one request and queue its characters. The unused
  // family yields nothing. A non-zero typed_first overrides the predicted
  // first character with a value read straight off the algorithm.
  task automatic queue_key(input logic [ksg_pkg::SEED_W-1:0] seed,
                           input logic [ksg_pkg::FUNC_W-1:0] fam,
                           input logic [7:0] typed_first);
    logic [31:0] v;
    int unsigned off;
    int unsigned prev;
    int unsigned alt;
    string       pri;
    string       sec;
    byte         b;
    key_sym_t    sym;
    if (fam == ksg_pkg::FAM_NONE) return;
    pri  = pri_set[fam];
    sec  = sec_set[fam];
    v    = seed;
    prev = 0;
    for (int p = 0; p < KEY_LEN; p++) begin
      // advance the seed by one shift step
      if (v[0]) v = ((v ^ MIX_ODD) >> 1) | MIX_TOP;
      else v = (v ^ MIX_EVEN) >> 1;
      off = v % ksg_pkg::CSET_LEN;
      if (p == 0 || off != prev) begin
        b = pri[off];
      end else begin
        // repeated offset: fall back to the secondary table
        alt = (prev + p - 1) % ksg_pkg::CSET_LEN;
        b   = sec[alt];
      end
      sym.ch = b[ksg_pkg::CHAR_W-1:0];
      if (p == 0 && typed_first != 8'd0) sym.ch = typed_first[ksg_pkg::CHAR_W-1:0];
      sym.idx  = p[ksg_pkg::IDX_W-1:0];
      sym.last = (p == KEY_LEN - 1);
      pending_chars.push_back(sym);
      prev = off;
    end
  endtask

  // Offer one request and hold it until the block takes it.
  task automatic offer_request(input logic [ksg_pkg::SEED_W-1:0] seed,
                               input logic [ksg_pkg::FUNC_W-1:0] fam,
                               input logic [7:0] typed_first);
    in_valid <= 1'b1;
    mac_low  <= seed;
    func     <= fam;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    queue_key(seed, fam, typed_first);
  endtask

  // Drop valid for a short random gap now and then, per the sender's rate.
  task automatic pace_sender();
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  // Random requests: mostly valid families, with some unused-family noise
  // that does not count toward the total.
  task automatic random_requests(input int count);
    int                         n;
    logic [ksg_pkg::FUNC_W-1:0] fam;
    logic [31:0]                seed;
    n = 0;
    while (n < count) begin
      seed = $urandom;
      if ($urandom_range(9) == 0) begin
        fam = ksg_pkg::FAM_NONE;
      end else begin
        fam = ksg_pkg::FUNC_W'($urandom_range(2, 0));
        n++;
      end
      offer_request(seed, fam, 8'd0);
      pace_sender();
    end
  endtask

  // Receiver: stall at random per the current rate, and hard during the
  // long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Long hold-off, counted here, started once the stimulus asks for it.
  initial begin
    while (!hold_go) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Check every character taken from the block against the oldest one owed.
  always @(posedge clk) begin : char_check
    key_sym_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected key character %0d at index %0d", key_char, char_index);
        mismatches++;
      end else begin
        want = pending_chars.pop_front();
        if (key_char !== want.ch) begin
          $error("key_char: expected %0d, got %0d", want.ch, key_char);
          mismatches++;
        end
        if (char_index !== want.idx) begin
          $error("char_index: expected %0d, got %0d", want.idx, char_index);
          mismatches++;
        end
        if (last_char !== want.last) begin
          $error("last_char: expected %0d, got %0d", want.last, last_char);
          mismatches++;
        end
      end
    end
  end

  // Guard against a hung block.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_mac_seeded_key_char_generator_core failed");
      $finish;
    end
  end

  initial begin
    // Directed table. Seed zero steps to 0x2190d, offset 1; seed 0x4321a
    // steps to zero, offset 0. Those first characters are typed in; the
    // unused family must produce nothing at all.
    dir_rows = '{
      '{32'h0000_0000, ksg_pkg::FAM_0,    "1"},
      '{32'h0000_0000, ksg_pkg::FAM_1,    "3"},
      '{32'h0000_0000, ksg_pkg::FAM_2,    "K"},
      '{32'h0000_0000, ksg_pkg::FAM_NONE, 8'd0},
      '{32'h0004_321a, ksg_pkg::FAM_0,    "0"},
      '{32'h0004_321a, ksg_pkg::FAM_2,    "J"},
      '{32'hffff_ffff, ksg_pkg::FAM_0,    8'd0},
      '{32'hffff_ffff, ksg_pkg::FAM_1,    8'd0},
      '{32'hffff_ffff, ksg_pkg::FAM_2,    8'd0},
      '{32'hffff_ffff, ksg_pkg::FAM_NONE, 8'd0},
      '{32'h8000_0000, ksg_pkg::FAM_0,    8'd0},
      '{32'h0000_0001, ksg_pkg::FAM_1,    8'd0},
      '{32'h7fff_ffff, ksg_pkg::FAM_2,    8'd0},
      '{32'haaaa_aaaa, ksg_pkg::FAM_0,    8'd0},
      '{32'h5555_5555, ksg_pkg::FAM_1,    8'd0},
      '{32'h1234_5678, ksg_pkg::FAM_NONE, 8'd0}
    };

    // Hold reset, then release it once.
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, then random requests: sender slow-ish, receiver stalling half the time.
    send_idle_pct <= 13;
    recv_idle_pct <= 48;
    for (int r = 0; r < N_ROWS; r++) begin
      offer_request(dir_rows[r].seed, dir_rows[r].fam, dir_rows[r].first_ch);
      pace_sender();
    end
    random_requests(70);

    // Pause the sender until every owed character has come out.
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);

    // Swap the pacing: sender idles often, receiver rarely.
    send_idle_pct <= 48;
    recv_idle_pct <= 13;
    random_requests(70);

    // No idling at all; hold the output off for a long stretch while the
    // sender keeps offering, so the block backs up onto its input.
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    hold_go       <= 1'b1;
    random_requests(64);

    // Drain and let any stray character show itself.
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_mac_seeded_key_char_generator_core passed");
    end else begin
      $display("tb_mac_seeded_key_char_generator_core failed");
    end
    $finish;
  end

endmodule

// ===== mac_seeded_key_char_generator_core.f =====
src/ksg_pkg.sv
src/ksg_step.sv
src/mac_seeded_key_char_generator_core.sv
tb/tb_mac_seeded_key_char_generator_core.sv
